FILE: rtl/core/kic_pkg.sv
// Package for the keypad integer calculator: key codes, operator codes,
// internal widths and the decimal power table. No dependencies.
package kic_pkg;

    localparam int DisplayDigitsDefault = 14;

    // Internal arithmetic is 64-bit two's complement.
    localparam int VAL_W  = 64;
    localparam int CHAR_W = 5;
    localparam int CNT_W  = 7;

    // Key kinds.
    localparam logic [2:0] KEY_DIGIT  = 3'd0;
    localparam logic [2:0] KEY_OPER   = 3'd1;
    localparam logic [2:0] KEY_EQUALS = 3'd2;
    localparam logic [2:0] KEY_NEGATE = 3'd3;
    localparam logic [2:0] KEY_CLEAR  = 3'd4;

    // Largest valid operator key code (remainder).
    localparam logic [2:0] OPC_MAX = 3'd4;

    // Pending operator codes.
    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_ADD  = 3'd1;
    localparam logic [2:0] P_SUB  = 3'd2;
    localparam logic [2:0] P_MUL  = 3'd3;
    localparam logic [2:0] P_DIV  = 3'd4;
    localparam logic [2:0] P_REM  = 3'd5;

    function automatic logic [VAL_W-1:0] kic_pow10(input logic [4:0] k);
        logic [VAL_W-1:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            default: p = 64'd10000000000000000000;
        endcase
        return p;
    endfunction

    // Position of the highest set bit plus one; used only at elaboration.
    function automatic int kic_bitlen(input logic [VAL_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < VAL_W; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/keypad_integer_calculator.sv
// Keypad integer calculator: one key in, one display description out.
// Digit, clear and plain operator keys go straight to the result; add and subtract run EXEC,
// SIGN, MAG, MOD, CNT and WB, negate starts at SIGN, multiply adds the MUL loop, divide and
// remainder DIV and QSEL, on the shared 65-bit adder/subtractor; a zero divisor ends at EXEC.
// One key at a time: a new key waits until the last result is in the output register.
// Reset (asynchronous, active low) sets the entry to "0", one character, no pending operator.
module keypad_integer_calculator
    import kic_pkg::*;
#(
    parameter int DISPLAY_DIGITS = DisplayDigitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [3:0]         digit,
    input  logic [2:0]         operator_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] display_value,
    output logic [3:0]         display_chars,
    output logic               error_shown,
    output logic [2:0]         pending_operator
);

    localparam logic [VAL_W-1:0] LIMIT = kic_pow10(5'(DISPLAY_DIGITS));
    localparam int LIMIT_BITS = kic_bitlen(LIMIT);
    localparam int MOD_SHIFT  = VAL_W - LIMIT_BITS;
    localparam logic [VAL_W-1:0] MOD_DIVISOR = LIMIT << MOD_SHIFT;
    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_SHIFT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DISPLAY_DIGITS - 1);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(VAL_W - 1);
    localparam logic [CHAR_W-1:0] MAX_CHARS = CHAR_W'(DISPLAY_DIGITS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_QSEL = 4'd4;
    localparam logic [3:0] S_SIGN = 4'd5;
    localparam logic [3:0] S_MAG  = 4'd6;
    localparam logic [3:0] S_MOD  = 4'd7;
    localparam logic [3:0] S_CNT  = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // What the current key does once a result has been formatted.
    localparam logic [1:0] K_NEG = 2'd0;
    localparam logic [1:0] K_EQ  = 2'd1;
    localparam logic [1:0] K_OP  = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [VAL_W-1:0]  first_reg, first_next;
    logic [VAL_W-1:0]  second_reg, second_next;
    logic [VAL_W-1:0]  shown_reg, shown_next;
    logic [CHAR_W-1:0] chars_reg, chars_next;
    logic [2:0]        pend_reg, pend_next;
    logic              fresh_reg, fresh_next;
    logic              err_reg, err_next;
    logic [2:0]        newop_reg, newop_next;
    logic [1:0]        kind_reg, kind_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic [VAL_W-1:0]  opa_reg, opa_next;
    logic [VAL_W-1:0]  opb_reg, opb_next;
    logic [VAL_W-1:0]  mag_reg, mag_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CHAR_W-1:0] ndig_reg, ndig_next;
    logic              sa_reg, sa_next;
    logic              sb_reg, sb_next;
    logic              negr_reg, negr_next;
    logic              negm_reg, negm_next;
    logic              out_valid_reg, out_valid_next;
    logic [47:0]       out_value_reg, out_value_next;
    logic [3:0]        out_chars_reg, out_chars_next;
    logic              out_err_reg, out_err_next;
    logic [2:0]        out_pend_reg, out_pend_next;

    // The shared adder/subtractor; carry out on subtract means a >= b.
    logic [VAL_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [VAL_W:0]   alu_sum;
    logic             alu_carry;
    logic [VAL_W-1:0] alu_res;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{VAL_W{1'b0}}, alu_sub};
    assign alu_carry = alu_sum[VAL_W];
    assign alu_res   = alu_sum[VAL_W-1:0];

    logic [VAL_W-1:0] times_ten;
    logic [VAL_W-1:0] digit_ext;
    logic [VAL_W-1:0] rem_shift;

    assign times_ten = (shown_reg << 3) + (shown_reg << 1);
    assign digit_ext = {{(VAL_W-4){1'b0}}, digit};
    assign rem_shift = {acc_reg[VAL_W-2:0], opa_reg[VAL_W-1]};

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        shown_next     = shown_reg;
        chars_next     = chars_reg;
        pend_next      = pend_reg;
        fresh_next     = fresh_reg;
        err_next       = err_reg;
        newop_next     = newop_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        ndig_next      = ndig_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        negr_next      = negr_reg;
        negm_next      = negm_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_value_next = out_value_reg;
        out_chars_next = out_chars_reg;
        out_err_next   = out_err_reg;
        out_pend_next  = out_pend_reg;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DONE;
                    case (func)
                        KEY_DIGIT:
                        begin
                            if (digit <= 4'd9)
                            begin
                                if (fresh_reg || err_reg)
                                begin
                                    shown_next = digit_ext;
                                    chars_next = CHAR_W'(1);
                                    fresh_next = 1'b0;
                                    err_next   = 1'b0;
                                end
                                else if (chars_reg < MAX_CHARS)
                                begin
                                    // A negative entry grows in magnitude.
                                    shown_next = shown_reg[VAL_W-1] ? times_ten - digit_ext
                                                                    : times_ten + digit_ext;
                                    chars_next = chars_reg + CHAR_W'(1);
                                end
                            end
                        end
                        KEY_OPER:
                        begin
                            if (operator_code <= OPC_MAX)
                            begin
                                newop_next = operator_code + 3'd1;
                                if (pend_reg != P_NONE)
                                begin
                                    second_next = shown_reg;
                                    kind_next   = K_OP;
                                    state_next  = S_EXEC;
                                end
                                else
                                begin
                                    first_next = shown_reg;
                                    pend_next  = operator_code + 3'd1;
                                    fresh_next = 1'b1;
                                end
                            end
                        end
                        KEY_EQUALS:
                        begin
                            if (pend_reg != P_NONE)
                            begin
                                second_next = shown_reg;
                                kind_next   = K_EQ;
                                state_next  = S_EXEC;
                            end
                        end
                        KEY_NEGATE:
                        begin
                            acc_next   = shown_reg;
                            negr_next  = 1'b1;
                            kind_next  = K_NEG;
                            state_next = S_SIGN;
                        end
                        KEY_CLEAR:
                        begin
                            first_next  = '0;
                            second_next = '0;
                            pend_next   = P_NONE;
                            shown_next  = '0;
                            chars_next  = CHAR_W'(1);
                            fresh_next  = 1'b1;
                            err_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                negr_next = 1'b0;
                case (pend_reg)
                    P_ADD, P_SUB:
                    begin
                        alu_a      = first_reg;
                        alu_b      = second_reg;
                        alu_sub    = (pend_reg == P_SUB);
                        acc_next   = alu_res;
                        state_next = S_SIGN;
                    end
                    P_MUL:
                    begin
                        acc_next   = '0;
                        opa_next   = first_reg;
                        opb_next   = second_reg;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    P_DIV, P_REM:
                    begin
                        if (second_reg == '0)
                        begin
                            // Division error: the pending operator stays unless a new
                            // operator key replaces it.
                            err_next   = 1'b1;
                            shown_next = '0;
                            chars_next = CHAR_W'(3);
                            if (kind_reg == K_OP)
                            begin
                                first_next = '0;
                                pend_next  = newop_reg;
                                fresh_next = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            alu_sub    = 1'b1;
                            alu_b      = first_reg;
                            sa_next    = first_reg[VAL_W-1];
                            sb_next    = second_reg[VAL_W-1];
                            opa_next   = first_reg[VAL_W-1] ? alu_res : first_reg;
                            opb_next   = second_reg[VAL_W-1] ? (~second_reg + 64'd1)
                                                             : second_reg;
                            acc_next   = '0;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        acc_next   = first_reg;
                        state_next = S_SIGN;
                    end
                endcase
            end
            S_MUL:
            begin
                alu_a    = acc_reg;
                alu_b    = opa_reg;
                if (opb_reg[0])
                begin
                    acc_next = alu_res;
                end
                opa_next = opa_reg << 1;
                opb_next = opb_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = S_SIGN;
                end
            end
            S_DIV:
            begin
                // Restoring division: opa shifts out the dividend and in the quotient.
                alu_a    = rem_shift;
                alu_b    = opb_reg;
                alu_sub  = 1'b1;
                acc_next = alu_carry ? alu_res : rem_shift;
                opa_next = {opa_reg[VAL_W-2:0], alu_carry};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = S_QSEL;
                end
            end
            S_QSEL:
            begin
                if (pend_reg == P_DIV)
                begin
                    acc_next  = opa_reg;
                    negr_next = sa_reg ^ sb_reg;
                end
                else
                begin
                    negr_next = sa_reg;
                end
                state_next = S_SIGN;
            end
            S_SIGN:
            begin
                alu_b      = acc_reg;
                alu_sub    = 1'b1;
                acc_next   = negr_reg ? alu_res : acc_reg;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                alu_b      = acc_reg;
                alu_sub    = 1'b1;
                negm_next  = acc_reg[VAL_W-1];
                acc_next   = acc_reg[VAL_W-1] ? alu_res : acc_reg;
                mag_next   = acc_reg[VAL_W-1] ? alu_res : acc_reg;
                opb_next   = MOD_DIVISOR;
                cnt_next   = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                // Reduce the magnitude modulo 10^DISPLAY_DIGITS by shifted subtraction.
                alu_a    = acc_reg;
                alu_b    = opb_reg;
                alu_sub  = 1'b1;
                if (alu_carry)
                begin
                    acc_next = alu_res;
                end
                opb_next = opb_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == MOD_LAST)
                begin
                    cnt_next   = CNT_W'(1);
                    ndig_next  = CHAR_W'(1);
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                // One decimal place per cycle: count the powers of ten not above the magnitude.
                alu_a    = mag_reg;
                alu_b    = kic_pow10(cnt_reg[4:0]);
                alu_sub  = 1'b1;
                if (alu_carry)
                begin
                    ndig_next = ndig_reg + CHAR_W'(1);
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg >= CNT_LAST)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                alu_b      = acc_reg;
                alu_sub    = 1'b1;
                shown_next = negm_reg ? alu_res : acc_reg;
                chars_next = ndig_reg + {{(CHAR_W-1){1'b0}}, negm_reg};
                err_next   = 1'b0;
                if (kind_reg != K_NEG)
                begin
                    first_next = negm_reg ? alu_res : acc_reg;
                    pend_next  = (kind_reg == K_OP) ? newop_reg : P_NONE;
                    fresh_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = shown_reg[47:0];
                    out_chars_next = chars_reg[3:0];
                    out_err_next   = err_reg;
                    out_pend_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            second_reg    <= '0;
            shown_reg     <= '0;
            chars_reg     <= CHAR_W'(1);
            pend_reg      <= P_NONE;
            fresh_reg     <= 1'b1;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            shown_reg     <= shown_next;
            chars_reg     <= chars_next;
            pend_reg      <= pend_next;
            fresh_reg     <= fresh_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newop_reg     <= newop_next;
        kind_reg      <= kind_next;
        acc_reg       <= acc_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        mag_reg       <= mag_next;
        cnt_reg       <= cnt_next;
        ndig_reg      <= ndig_next;
        sa_reg        <= sa_next;
        sb_reg        <= sb_next;
        negr_reg      <= negr_next;
        negm_reg      <= negm_next;
        out_value_reg <= out_value_next;
        out_chars_reg <= out_chars_next;
        out_err_reg   <= out_err_next;
        out_pend_reg  <= out_pend_next;
    end

    assign out_valid        = out_valid_reg;
    assign display_value    = out_value_reg;
    assign display_chars    = out_chars_reg;
    assign error_shown      = out_err_reg;
    assign pending_operator = out_pend_reg;

endmodule
